// ----- src/prefill_watermark_fifo_unit_defines.svh -----
// ----------------------------------------------------------------------------
// prefill watermark fifo assertion macros
// shared check wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef PREFILL_WATERMARK_FIFO_UNIT_DEFINES_SVH
`define PREFILL_WATERMARK_FIFO_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define PWF_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PWF_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/pwf_pkg.sv -----
// ----------------------------------------------------------------------------
// pwf_pkg
// types and constants of the prefill watermark fifo
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwf_pkg;

  // ring depth in bytes, a power of two so the indices wrap on their own
  localparam int DEPTH  = 65536;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int BYTE_W = 8;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_PULL = 2'd1,
    REQ_END  = 2'd2,
    REQ_NOP  = 2'd3
  } req_t;

  typedef struct packed {
    req_t              req_type;
    logic [BYTE_W-1:0] in_byte;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              dropped;
    logic [CNT_W-1:0]  fill_level;
    logic              released;
    logic              finished;
  } out_word_t;

  // zero or anything above the depth means the full depth
  function automatic logic [CNT_W-1:0] eff_start(input logic [CNT_W-1:0] lvl);
    if (lvl == '0 || lvl > DEPTH_CNT) begin
      return DEPTH_CNT;
    end
    return lvl;
  endfunction

endpackage

// ----- src/pwf_ram.sv -----
// ----------------------------------------------------------------------------
// pwf_ram
// simple dual port ram, one write and one read port, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- src/prefill_watermark_fifo_unit.sv -----
// ----------------------------------------------------------------------------
// prefill_watermark_fifo_unit
// byte ring buffer with a start threshold, one status word out per word in
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// in       in         in_valid / in_ready   in_data   (req_type, in_byte)
// out      out        out_valid / out_ready out_data  (byte, status, fill level)
// cfg      in         cfg_valid / cfg_ready cfg_data  (start level)
//
// one word per cycle while the output is not stalled; a word's result passes
// stage 1 (beside the ram read) and then the output register to out_data.
// pointers and count update at acceptance; the ring ram has one write and one read port.
// synchronous active-low reset clears pointers, count and flags; ram is not
// cleared. cfg_ready is always high. a stalled output holds the middle stage
// and stops acceptance only once both stages are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "prefill_watermark_fifo_unit_defines.svh"

module prefill_watermark_fifo_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pwf_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pwf_pkg::out_word_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pwf_pkg::CNT_W-1:0]   cfg_data
);

  import pwf_pkg::*;

  logic [CNT_W-1:0]  start_r;
  logic [ADDR_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic              open_r, open_nxt;
  logic              ended_r, ended_nxt;

  logic              s1_v_r;
  logic              s1_pull_r;
  out_word_t         s1_word_r;
  logic              out_v_r;
  out_word_t         out_word_r;

  logic              s1_adv;
  logic              in_acc;
  logic              do_push;
  logic              do_pull;
  logic              do_drop;
  logic [BYTE_W-1:0] rdata;
  out_word_t         s1_word_nxt;
  out_word_t         out_word_nxt;

  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_v_r || out_ready;
  assign in_ready  = !s1_v_r || s1_adv;
  assign in_acc    = in_valid && in_ready;

  assign do_push = in_acc && in_data.req_type == REQ_PUSH && !ended_r && held_r != DEPTH_CNT;
  assign do_drop = in_acc && in_data.req_type == REQ_PUSH && !ended_r && held_r == DEPTH_CNT;
  assign do_pull = in_acc && in_data.req_type == REQ_PULL && open_r && held_r != '0;

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    held_nxt   = held_r;
    open_nxt   = open_r;
    ended_nxt  = ended_r;
    if (do_push) begin
      wr_idx_nxt = wr_idx_r + 1'b1;
      held_nxt   = held_r + 1'b1;
      if (held_nxt >= eff_start(start_r)) begin
        open_nxt = 1'b1;
      end
    end
    if (do_pull) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
      held_nxt   = held_r - 1'b1;
    end
    if (in_acc && in_data.req_type == REQ_END) begin
      ended_nxt = 1'b1;
      open_nxt  = 1'b1;
    end
  end

  always_comb begin
    s1_word_nxt            = '0;
    s1_word_nxt.dropped    = do_drop;
    s1_word_nxt.fill_level = held_nxt;
    s1_word_nxt.released   = open_nxt;
    s1_word_nxt.finished   = ended_nxt && held_nxt == '0;
  end

  pwf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (do_push),
    .waddr   (wr_idx_r),
    .wdata   (in_data.in_byte),
    .re      (do_pull),
    .raddr   (rd_idx_r),
    .rdata_r (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= DEPTH_CNT;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      held_r   <= '0;
      open_r   <= 1'b0;
      ended_r  <= 1'b0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        start_r <= cfg_data;
      end
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      held_r   <= held_nxt;
      open_r   <= open_nxt;
      ended_r  <= ended_nxt;
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_comb begin
    out_word_nxt = s1_word_r;
    // ram data is still held here since no read issues while stage 1 waits
    if (s1_pull_r) begin
      out_word_nxt.out_byte  = rdata;
      out_word_nxt.out_valid = 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r <= s1_word_nxt;
      s1_pull_r <= do_pull;
    end
    if (s1_adv && s1_v_r) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_word_r;

  `PWF_CHECK(a_held_bound, held_r <= DEPTH_CNT, "fill count above depth")
  `PWF_CHECK(a_held_ptrs, held_r[ADDR_W-1:0] == wr_idx_r - rd_idx_r, "count and pointers disagree")
  `PWF_CHECK_NEXT(a_open_sticky, open_r, open_r, "release flag fell")
  `PWF_CHECK_NEXT(a_s1_hold, s1_v_r && !s1_adv, s1_v_r && $stable(s1_word_r), "stage 1 word lost")

endmodule
